[src/sha1_pkg.sv]
package sha1_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 80;
  localparam int unsigned DigestWords = 5;

  localparam logic [6:0] RoundLast = 7'(Rounds - 1);

  // H0 sits at index 0
  localparam logic [4:0][31:0] HashInit = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h8f1bbcdc;
  localparam word_t K3 = 32'hca62c1d6;

  localparam word_t PadByte = 32'h80000000;

  // pad marker must leave room for the two length words
  localparam logic [5:0] PadLimit = 6'd56;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StPad    = 7'b0000010,
    StLen    = 7'b0000100,
    StStart  = 7'b0001000,
    StRound  = 7'b0010000,
    StFinish = 7'b0100000,
    StDone   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic       accept;
    logic       pad;
    logic       len;
    logic       start;
    logic       round;
    logic [6:0] round_idx;
    logic       finish;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic blk_full;
    logic pad_over;
    logic out_free;
  } dp_sts_t;

  function automatic word_t rotl(input word_t v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  function automatic word_t byte_mask(input logic [2:0] n);
    case (n)
      3'd0:    byte_mask = 32'h00000000;
      3'd1:    byte_mask = 32'hff000000;
      3'd2:    byte_mask = 32'hffff0000;
      3'd3:    byte_mask = 32'hffffff00;
      default: byte_mask = 32'hffffffff;
    endcase
  endfunction

  function automatic word_t round_f(input logic [6:0] r, input word_t b,
                                    input word_t c, input word_t d);
    if (r < 7'd20) begin
      round_f = d ^ (b & (c ^ d));
    end else if (r < 7'd40) begin
      round_f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      round_f = (b & c) | (b & d) | (c & d);
    end else begin
      round_f = b ^ c ^ d;
    end
  endfunction

  function automatic word_t round_k(input logic [6:0] r);
    if (r < 7'd20) begin
      round_k = K0;
    end else if (r < 7'd40) begin
      round_k = K1;
    end else if (r < 7'd60) begin
      round_k = K2;
    end else begin
      round_k = K3;
    end
  endfunction

endpackage

[src/sha1_ctrl.sv]
module sha1_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  sha1_pkg::dp_sts_t sts_i,
  output sha1_pkg::dp_cmd_t cmd_o
);
  import sha1_pkg::*;

  state_e     state_q, state_d;
  state_e     ret_q, ret_d;
  logic [6:0] rnd_q, rnd_d;
  logic       acc;

  assign in_ready_o = (state_q == StIdle);
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    rnd_d   = rnd_q;
    cmd_o   = '0;
    cmd_o.round_idx = rnd_q;
    case (state_q)
      StIdle: begin
        if (acc) begin
          cmd_o.accept = 1'b1;
          if (sts_i.blk_full) begin
            state_d = StStart;
            ret_d   = in_last_i ? StPad : StIdle;
          end else if (in_last_i) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        cmd_o.pad = 1'b1;
        state_d   = StStart;
        if (sts_i.pad_over) begin
          ret_d = StLen;
        end else begin
          cmd_o.len = 1'b1;
          ret_d     = StDone;
        end
      end
      StLen: begin
        cmd_o.len = 1'b1;
        state_d   = StStart;
        ret_d     = StDone;
      end
      StStart: begin
        cmd_o.start = 1'b1;
        rnd_d       = '0;
        state_d     = StRound;
      end
      StRound: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 7'd1;
        if (rnd_q == RoundLast) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        state_d      = ret_q;
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ret_q   <= StIdle;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      rnd_q   <= rnd_d;
    end
  end

endmodule

[src/sha1_dpath.sv]
module sha1_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       data_word_i,
  input  logic [2:0]        byte_count_i,
  input  sha1_pkg::dp_cmd_t cmd_i,
  output sha1_pkg::dp_sts_t sts_o,
  output logic [31:0]       digest_word_o,
  output logic [2:0]        word_index_o,
  output logic              out_valid_o,
  output logic              out_last_o,
  input  logic              out_ready_i
);
  import sha1_pkg::*;

  // block buffer doubles as the message schedule window
  word_t [BlockWords-1:0]  w_q;
  word_t [DigestWords-1:0] h_q;
  word_t [DigestWords-1:0] out_q;
  word_t                   a_q, b_q, c_q, d_q, e_q;
  word_t                   carry_q;
  logic [5:0]              fill_q;
  logic [63:0]             bits_q;
  logic [2:0]              out_cnt_q;

  logic [2:0]  n_eff;
  logic [6:0]  fill_sum;
  logic [63:0] ins;
  logic [3:0]  idx, idx_nx;
  word_t       t_val, w_new, pad_w;
  logic        out_acc;

  assign n_eff    = byte_count_i[2] ? 3'd4 : byte_count_i;
  assign fill_sum = {1'b0, fill_q} + {4'b0, n_eff};
  assign ins      = {data_word_i & byte_mask(n_eff), 32'h0} >> {fill_q[1:0], 3'b000};
  assign idx      = fill_q[5:2];
  assign idx_nx   = idx + 4'd1;
  assign pad_w    = PadByte >> {fill_q[1:0], 3'b000};

  assign t_val = rotl(a_q, 5) + round_f(cmd_i.round_idx, b_q, c_q, d_q) + e_q
               + round_k(cmd_i.round_idx) + w_q[0];
  assign w_new = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);

  assign sts_o.blk_full = fill_sum[6];
  assign sts_o.pad_over = (fill_q >= PadLimit);
  assign sts_o.out_free = (out_cnt_q == '0);

  assign out_valid_o   = (out_cnt_q != '0);
  assign out_acc       = out_valid_o && out_ready_i;
  assign digest_word_o = out_q[0];
  assign word_index_o  = 3'(DigestWords) - out_cnt_q;
  assign out_last_o    = (out_cnt_q == 3'd1);

  // buffer, fill and bit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= '0;
      carry_q <= '0;
      fill_q  <= '0;
      bits_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        w_q[idx] <= w_q[idx] | ins[63:32];
        if (idx != 4'd15) begin
          w_q[idx_nx] <= w_q[idx_nx] | ins[31:0];
        end else begin
          carry_q <= ins[31:0];
        end
        fill_q <= fill_sum[5:0];
        bits_q <= bits_q + {58'b0, n_eff, 3'b000};
      end
      if (cmd_i.pad) begin
        w_q[idx] <= w_q[idx] | pad_w;
      end
      if (cmd_i.len) begin
        w_q[14] <= bits_q[63:32];
        w_q[15] <= bits_q[31:0];
      end
      if (cmd_i.round) begin
        for (int i = 0; i < BlockWords - 1; i++) begin
          w_q[i] <= w_q[i+1];
        end
        w_q[BlockWords-1] <= w_new;
      end
      if (cmd_i.finish) begin
        // fresh block holds only the bytes that spilled past the old one
        w_q     <= {{(BlockWords-1){32'h0}}, carry_q};
        carry_q <= '0;
      end
      if (cmd_i.emit) begin
        fill_q <= '0;
        bits_q <= '0;
      end
    end
  end

  // chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= HashInit;
    end else if (cmd_i.finish) begin
      h_q[0] <= h_q[0] + a_q;
      h_q[1] <= h_q[1] + b_q;
      h_q[2] <= h_q[2] + c_q;
      h_q[3] <= h_q[3] + d_q;
      h_q[4] <= h_q[4] + e_q;
    end else if (cmd_i.emit) begin
      h_q <= HashInit;
    end
  end

  // working variables
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (cmd_i.round) begin
      a_q <= t_val;
      b_q <= a_q;
      c_q <= rotl(b_q, 30);
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  // digest output queue
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= h_q;
    end else if (out_acc) begin
      for (int i = 0; i < DigestWords - 1; i++) begin
        out_q[i] <= out_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
    end else if (cmd_i.emit) begin
      out_cnt_q <= 3'(DigestWords);
    end else if (out_acc) begin
      out_cnt_q <= out_cnt_q - 3'd1;
    end
  end

endmodule

[src/sha1_hash_engine.sv]
// SHA-1 message hasher.
// Input stream: each transaction carries up to four message bytes in
// tdata[31:0] (first byte in bits 31..24), the byte count in tdata[34:32]
// (5 to 7 count as 4) and tlast on the final transaction of a message.
// Output stream: five transactions per message, digest word H0 first,
// word index in tdata[34:32], tlast on the fifth word.
// Flow: input is accepted only while the engine is idle. A transaction
// that completes a 64-byte block starts a compression (a load step, the
// rounds one at a time, an add step), and no further input is taken until
// it ends. A last transaction, after any compression of its own block,
// adds padding and compresses once more before the digest is loaded, or
// twice when the pad marker falls beyond byte 55. A single round unit
// does all compressions.
// The digest sits in its own five-word queue, so a new message may be
// accepted while the receiver stalls; only loading the next digest waits
// for the queue to drain.
// Reset (rst_ni low, asynchronous) restores the initial hash, clears the
// block buffer, byte fill and bit count, and empties the digest queue.
module sha1_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // data_word[31:0], byte_count[34:32], zero pad
  input  logic        s_axis_tlast_i,  // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // digest_word[31:0], word_index[34:32], zero pad
  output logic        m_axis_tlast_o   // last_word
);
  import sha1_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  // controller: sequences insert, padding, rounds and digest load
  sha1_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: block buffer, round unit, chaining value, digest queue
  sha1_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_word_i   (s_axis_tdata_i[31:0]),
    .byte_count_i  (s_axis_tdata_i[34:32]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .digest_word_o (digest_word),
    .word_index_o  (word_index),
    .out_valid_o   (m_axis_tvalid_o),
    .out_last_o    (m_axis_tlast_o),
    .out_ready_i   (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {5'b0, word_index, digest_word};

endmodule

[tb/sha1_hash_engine_tb.sv]
module sha1_hash_engine_tb;
  import sha1_pkg::*;

  localparam int ClkPeriod   = 12;
  localparam int RandomItems = 200;
  localparam int HoldCycles  = 3000;   // long receiver hold-off, fills the digest queue
  localparam int DrainCycles = 200;    // covers a two-block pad plus digest load
  localparam int LimitCycles = 500000;

  // well-known digests, H0 in the top bits
  localparam logic [159:0] EmptyDigest = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
  localparam logic [159:0] AbcDigest   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

  localparam logic [2:0] LastWordIdx = 3'(DigestWords - 1);

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;   // data_word[31:0], byte_count[34:32], zero pad
  logic        s_axis_tlast_i;   // last
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;   // digest_word[31:0], word_index[34:32], zero pad
  logic        m_axis_tlast_o;   // last_word

  sha1_hash_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // one expected output transaction
  typedef struct {
    word_t      digest;
    logic [2:0] idx;
    logic       fin;
  } digest_beat_t;

  // directed stimulus row: the item is sent reps times, tlast only on the final copy;
  // where known is set the digest below is taken as the expected result
  typedef struct {
    word_t        data;
    logic [2:0]   cnt;
    logic         fin;
    int           reps;
    logic         known;
    logic [159:0] digest;
  } stim_row_t;

  localparam int NumRows = 14;
  stim_row_t dir_rows [NumRows] = '{
    '{32'h00000000, 3'd0, 1'b1, 1, 1'b1, EmptyDigest},  // empty message
    '{32'h616263a5, 3'd3, 1'b1, 1, 1'b1, AbcDigest},    // "abc", junk in unused byte
    '{32'h61ffffff, 3'd1, 1'b0, 1, 1'b0, '0},           // "abc" split over three
    '{32'h62635a5a, 3'd2, 1'b0, 1, 1'b0, '0},
    '{32'h00000000, 3'd0, 1'b1, 1, 1'b1, AbcDigest},    // empty last item closes it
    '{32'h61626364, 3'd7, 1'b1, 1, 1'b0, '0},           // counts above four clamp
    '{32'h61626364, 3'd5, 1'b0, 1, 1'b0, '0},
    '{32'hffffffff, 3'd6, 1'b1, 1, 1'b0, '0},
    '{32'h00000000, 3'd4, 1'b0, 1, 1'b0, '0},           // data extremes
    '{32'hffffffff, 3'd4, 1'b1, 1, 1'b0, '0},
    '{32'hffffffff, 3'd0, 1'b0, 3, 1'b0, '0},           // empty items mid-message
    '{32'hcafef00d, 3'd2, 1'b1, 1, 1'b0, '0},
    '{32'h80000000, 3'd1, 1'b0, 1, 1'b0, '0},
    '{32'h7fffffff, 3'd4, 1'b1, 1, 1'b0, '0}
  };

  // own model of the hasher
  word_t        hash_st [5];
  word_t        blk     [16];
  logic [63:0]  msg_bits;
  logic [5:0]   fill;
  digest_beat_t digest_q [$];

  int   mismatches = 0;
  bit   send_calm  = 1'b0;   // sender offers back to back while set
  bit   hold_req   = 1'b0;   // asks the receiver for its long hold-off

  function automatic void restart_hash();
    hash_st = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0};
    blk      = '{default: '0};
    msg_bits = '0;
    fill     = '0;
  endfunction

  function automatic word_t rot_left(input word_t v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // 80-round compression over blk, then the buffer is cleared
  function automatic void hash_block();
    word_t sched [80];
    word_t a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) sched[i] = blk[i];
    for (int i = 16; i < 80; i++) begin
      sched[i] = rot_left(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
    end
    a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3]; e = hash_st[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = d ^ (b & (c ^ d));            k = 32'h5a827999;
      end else if (i < 40) begin
        f = b ^ c ^ d;                    k = 32'h6ed9eba1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);  k = 32'h8f1bbcdc;
      end else begin
        f = b ^ c ^ d;                    k = 32'hca62c1d6;
      end
      t = rot_left(a, 5) + f + e + k + sched[i];
      e = d; d = c; c = rot_left(b, 30); b = a; a = t;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d; hash_st[4] += e;
    blk = '{default: '0};
  endfunction

  // takes one accepted input item; returns 1 with the digest when the message closes
  function automatic bit absorb_item(input word_t d, input logic [2:0] cnt, input logic fin,
                                     output logic [159:0] dig);
    int unsigned n;
    n   = (cnt > 3'd4) ? 4 : cnt;
    dig = '0;
    for (int i = 0; i < n; i++) begin
      blk[fill[5:2]] |= {24'h0, d[31-8*i -: 8]} << (24 - 8 * fill[1:0]);
      fill++;
      if (fill == 6'd0) hash_block();
    end
    msg_bits += 64'(8 * n);
    if (!fin) return 1'b0;
    // pad marker, then a spare block if it lands past byte 55
    blk[fill[5:2]] |= 32'h80 << (24 - 8 * fill[1:0]);
    if (fill >= 6'd56) hash_block();
    blk[14] = msg_bits[63:32];
    blk[15] = msg_bits[31:0];
    hash_block();
    dig = {hash_st[0], hash_st[1], hash_st[2], hash_st[3], hash_st[4]};
    restart_hash();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input word_t want, input word_t got);
    $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  // idle length: mostly none or short, a few long; none at all in calm stretches
  function automatic int pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sends one item; the model absorbs it at the accepting edge
  task automatic push_item(input word_t d, input logic [2:0] cnt, input logic fin,
                           input logic known, input logic [159:0] known_dig);
    int           gap;
    logic [159:0] dig;
    bit           closed;
    gap = pick_gap(send_calm);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {5'b0, cnt, d};
    s_axis_tlast_i  = fin;
    do @(posedge clk_i); while (!s_axis_tready_o);
    closed = absorb_item(d, cnt, fin, dig);
    if (closed) begin
      if (known) dig = known_dig;
      for (int i = 0; i < DigestWords; i++) begin
        digest_q.push_back('{dig[159-32*i -: 32], 3'(i), (3'(i) == LastWordIdx)});
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(ClkPeriod * LimitCycles);
    $display("FAIL sha1_hash_engine");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int run;
    int stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk_i);
        m_axis_tready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      repeat (run) begin
        @(negedge clk_i);
        m_axis_tready_i = 1'b1;
      end
      stall = pick_gap(1'b0);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready_i = 1'b0;
      end
    end
  end

  // output checker: each digest transaction against the oldest expectation
  always @(posedge clk_i) begin
    digest_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest word", '0, m_axis_tdata_o[31:0]);
      end else begin
        want = digest_q.pop_front();
        if (m_axis_tdata_o[31:0] !== want.digest)
          report_mismatch("digest_word", want.digest, m_axis_tdata_o[31:0]);
        if (m_axis_tdata_o[34:32] !== want.idx)
          report_mismatch("word_index", 32'(want.idx), 32'(m_axis_tdata_o[34:32]));
        if (m_axis_tlast_o !== want.fin)
          report_mismatch("last_word", 32'(want.fin), 32'(m_axis_tlast_o));
      end
    end
  end

  // stimulus: directed table first, then random messages
  initial begin
    int          sent;
    int          shape;
    int          body;
    logic        fin;
    logic [2:0]  cnt;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    restart_hash();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < NumRows; r++) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        push_item(dir_rows[r].data, dir_rows[r].cnt,
                  dir_rows[r].fin && (k == dir_rows[r].reps - 1),
                  dir_rows[r].known, dir_rows[r].digest);
      end
    end

    // the receiver now holds off for a while so the engine backs up
    hold_req = 1'b1;
    sent = 0;
    while (sent < RandomItems) begin
      // short messages, ones near the pad boundary, long multi-block ones, ragged ones
      shape     = $urandom_range(0, 9);
      send_calm = ($urandom_range(0, 3) == 0);
      if (shape < 5)       body = $urandom_range(0, 8);
      else if (shape < 8)  body = $urandom_range(13, 16);
      else if (shape == 8) body = $urandom_range(17, 40);
      else                 body = $urandom_range(0, 20);
      for (int k = 0; k <= body; k++) begin
        fin = (k == body);
        if (fin || shape == 9 || (shape < 5 && $urandom_range(0, 3) == 0))
          cnt = 3'($urandom_range(0, 7));
        else
          cnt = 3'd4;
        push_item($urandom, cnt, fin, 1'b0, '0);
        sent++;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;

    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS sha1_hash_engine");
    end else begin
      $display("FAIL sha1_hash_engine");
    end
    $finish;
  end

endmodule

[sha1_hash_engine.f]
src/sha1_pkg.sv
src/sha1_ctrl.sv
src/sha1_dpath.sv
src/sha1_hash_engine.sv
tb/sha1_hash_engine_tb.sv
